// ===== rtl/irkbd_pkg.sv =====
`timescale 1ns / 1ps

package irkbd_pkg;

   localparam int FRAME_CELLS = 9;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int TIME_W      = 20;
   localparam int TICKS_W     = 11;
   localparam int SCALE_W     = 8;
   localparam int PROD_W      = TICKS_W + SCALE_W;
   localparam int WIDE_W      = TIME_W + 2;
   localparam int KIND_W      = 8;
   localparam int CODE_W      = 9;
   localparam int PHASE_W     = 4;
   localparam int COUNT_W     = 4;

   localparam logic [KIND_W-1:0] KIND_SHORT = 8'h94;
   localparam logic [KIND_W-1:0] KIND_LONG  = 8'hd4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_TICK_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_MIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_MAX   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_CELL  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CELL       = 3'd6;

   // decoder phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_LEAD   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_S3     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_S4     = 4'd4;
   localparam logic [PHASE_W-1:0] PH_S5     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_SPLIT  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_S7     = 4'd7;
   localparam logic [PHASE_W-1:0] PH_S8     = 4'd8;
   localparam logic [PHASE_W-1:0] PH_SHORT  = 4'd9;
   localparam logic [PHASE_W-1:0] PH_LONG   = 4'd10;
   localparam logic [PHASE_W-1:0] PH_CELLS  = 4'd11;
   localparam logic [PHASE_W-1:0] PH_CELLS2 = 4'd12;
   localparam logic [PHASE_W-1:0] PH_DATA   = 4'd13;

   typedef struct packed {
      logic                 is_high;
      logic [2:0]           mult;
      logic [PHASE_W-1:0]   next_phase;
      logic                 retry;
      logic                 set_kind;
      logic [KIND_W-1:0]    kind;
   } win_type;

   function automatic win_type win_lookup(input logic [PHASE_W-1:0] ph, input logic second);
      win_type w;
      w = '{is_high: 1'b0, mult: 3'd1, next_phase: PH_IDLE, retry: 1'b0,
            set_kind: 1'b0, kind: '0};
      case (ph)
         PH_IDLE, PH_LEAD: begin
            w.mult = 3'd3; w.next_phase = PH_S3;
         end
         PH_S3: begin
            w.is_high = 1'b1; w.next_phase = PH_S4;
         end
         PH_S4: begin
            w.next_phase = PH_S5;
         end
         PH_S5: begin
            w.is_high = 1'b1; w.next_phase = PH_SPLIT;
         end
         PH_SPLIT: begin
            // double width leads to the short start, single width to the long one
            if (second) begin
               w.next_phase = PH_LONG;
            end else begin
               w.mult = 3'd2; w.next_phase = PH_S7; w.retry = 1'b1;
            end
         end
         PH_S7: begin
            w.is_high = 1'b1; w.next_phase = PH_S8;
         end
         PH_S8: begin
            w.next_phase = PH_SHORT;
         end
         PH_SHORT: begin
            w.is_high = 1'b1; w.next_phase = PH_CELLS;
            w.set_kind = 1'b1; w.kind = KIND_SHORT;
         end
         PH_LONG: begin
            w.is_high = 1'b1; w.mult = 3'd4; w.next_phase = PH_CELLS;
            w.set_kind = 1'b1; w.kind = KIND_LONG;
         end
         default: begin
            w.next_phase = PH_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic [WIDE_W-1:0] scale_by_m(input logic [TIME_W-1:0] x,
                                                    input logic [2:0] m);
      logic [WIDE_W-1:0] xw;
      logic [WIDE_W-1:0] r;
      xw = {2'b00, x};
      case (m)
         3'd2:    r = xw << 1;
         3'd3:    r = (xw << 1) + xw;
         3'd4:    r = xw << 2;
         default: r = xw;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ir_keyboard_pulse_decoder.sv =====
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                  | tuser
// req     | in  | pulse_level, pulse_ticks[10:0], pad | -
// rsp     | out | key_code[8:0], pad                  | frame_kind[7:0]
// csr     | in  | index[2:0], data[19:0]              | -
//
// one pulse at a time: accept, tick scaling multiply, dispatch, then either two
// window compares (four when the split phase falls back) or one compare/subtract
// step per bit cell (up to nine) and a closing step; a high pulse in a cells
// phase drops the frame. window and cell compares share one comparator.
// reset is synchronous; it clears the sequencer, the decoder state and the
// csr registers to their defaults. a full result register holds the closing step.
module ir_keyboard_pulse_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,   // pulse_level, pulse_ticks
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,   // key_code
   output logic [7:0]                           rsp_tuser,   // frame_kind
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [irkbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [irkbd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import irkbd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DISP = 3'd2;
   localparam logic [2:0] S_WLO  = 3'd3;
   localparam logic [2:0] S_WHI  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [CODE_W-1:0]   shift_ff, shift_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                lvl_ff, lvl_in;
   logic [TICKS_W-1:0]  ticks_ff, ticks_in;
   logic [PROD_W-1:0]   t_ff, t_in;
   logic [PROD_W-1:0]   rem_ff, rem_in;
   logic                unl_ff, unl_in;
   logic                try_ff, try_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;

   logic [SCALE_W-1:0]  tick_scale_ff;
   logic [TIME_W-1:0]   low_min_ff, low_max_ff, high_min_ff, high_max_ff;
   logic [TIME_W-1:0]   half_cell_ff, cell_ff;

   win_type             win;
   logic [TIME_W-1:0]   win_min, win_max;
   logic [WIDE_W-1:0]   cmp_a, cmp_b;
   logic                cmp_le;
   logic [TIME_W-1:0]   diff;
   logic                out_free;
   logic [COUNT_W-1:0]  fin_count;
   logic [CODE_W-1:0]   fin_shift;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_code_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign win     = win_lookup(phase_ff, try_ff);
   assign win_min = win.is_high ? high_min_ff : low_min_ff;
   assign win_max = win.is_high ? high_max_ff : low_max_ff;
   assign diff    = {1'b0, t_ff} - half_cell_ff;

   // the shared comparator: a <= b
   always_comb begin
      case (state_ff)
         S_DISP: begin
            cmp_a = {2'b00, half_cell_ff};
            cmp_b = {3'b000, t_ff};
         end
         S_WLO: begin
            cmp_a = scale_by_m(win_min, win.mult);
            cmp_b = {3'b000, t_ff};
         end
         S_WHI: begin
            cmp_a = {3'b000, t_ff};
            cmp_b = scale_by_m(win_max, win.mult);
         end
         S_DIV: begin
            cmp_a = {2'b00, cell_ff};
            cmp_b = {3'b000, rem_ff};
         end
         default: begin
            cmp_a = '0;
            cmp_b = '0;
         end
      endcase
   end
   assign cmp_le = (cmp_a <= cmp_b);

   // closing step: a frame one cell short gets its final one
   always_comb begin
      if (count_ff == COUNT_W'(FRAME_CELLS - 1)) begin
         fin_count = count_ff + 1'b1;
         fin_shift = {1'b1, shift_ff[CODE_W-1:1]};
      end else begin
         fin_count = count_ff;
         fin_shift = shift_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      lvl_in       = lvl_ff;
      ticks_in     = ticks_ff;
      t_in         = t_ff;
      rem_in       = rem_ff;
      unl_in       = unl_ff;
      try_in       = try_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_code_in  = rsp_code_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               lvl_in   = req_tdata[0];
               ticks_in = req_tdata[TICKS_W:1];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            t_in     = {{SCALE_W{1'b0}}, ticks_ff} * {{TICKS_W{1'b0}}, tick_scale_ff};
            state_in = S_DISP;
         end
         S_DISP: begin
            try_in = 1'b0;
            unl_in = !cmp_le || (cell_ff == '0);
            rem_in = diff[PROD_W-1:0];
            case (phase_ff)
               PH_IDLE: begin
                  kind_in  = '0;
                  shift_in = '0;
                  count_in = '0;
                  state_in = S_WLO;
               end
               PH_LEAD, PH_S3, PH_S4, PH_S5, PH_SPLIT, PH_S7, PH_S8, PH_SHORT,
               PH_LONG: begin
                  state_in = S_WLO;
               end
               PH_CELLS, PH_CELLS2: begin
                  if (lvl_ff) begin
                     phase_in = PH_IDLE;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_DIV;
                  end
               end
               PH_DATA: begin
                  shift_in = {lvl_ff, shift_ff[CODE_W-1:1]};
                  count_in = count_ff + 1'b1;
                  state_in = S_DIV;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WLO: begin
            if ((lvl_ff == win.is_high) && cmp_le) begin
               state_in = S_WHI;
            end else if (win.retry) begin
               try_in = 1'b1;
            end else begin
               phase_in = PH_IDLE;
               state_in = S_IDLE;
            end
         end
         S_WHI: begin
            if (cmp_le) begin
               phase_in = win.next_phase;
               if (win.set_kind) begin
                  kind_in = win.kind;
               end
               state_in = S_IDLE;
            end else if (win.retry) begin
               try_in   = 1'b1;
               state_in = S_WLO;
            end else begin
               phase_in = PH_IDLE;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            // one cell per step until the pulse is used up or the frame is full
            if ((count_ff < COUNT_W'(FRAME_CELLS)) && (unl_ff || cmp_le)) begin
               rem_in   = rem_ff - cell_ff[PROD_W-1:0];
               count_in = count_ff + 1'b1;
               if (phase_ff == PH_DATA) begin
                  shift_in = {lvl_ff, shift_ff[CODE_W-1:1]};
               end
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               count_in = fin_count;
               shift_in = fin_shift;
               if (fin_count == COUNT_W'(FRAME_CELLS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = kind_ff;
                  rsp_code_in  = fin_shift;
                  phase_in     = PH_IDLE;
               end else begin
                  phase_in = PH_DATA;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_IDLE;
         kind_ff       <= '0;
         shift_ff      <= '0;
         count_ff      <= '0;
         try_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tick_scale_ff <= 8'd15;
         low_min_ff    <= '0;
         low_max_ff    <= '0;
         high_min_ff   <= '0;
         high_max_ff   <= '0;
         half_cell_ff  <= '0;
         cell_ff       <= TIME_W'(1);
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         try_ff       <= try_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TICK_SCALE: tick_scale_ff <= csr_data[SCALE_W-1:0];
               REG_LOW_MIN:    low_min_ff    <= csr_data;
               REG_LOW_MAX:    low_max_ff    <= csr_data;
               REG_HIGH_MIN:   high_min_ff   <= csr_data;
               REG_HIGH_MAX:   high_max_ff   <= csr_data;
               REG_HALF_CELL:  half_cell_ff  <= csr_data;
               REG_CELL:       cell_ff       <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      ticks_ff    <= ticks_in;
      t_ff        <= t_in;
      rem_ff      <= rem_in;
      unl_ff      <= unl_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_code_ff <= rsp_code_in;
   end

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(FRAME_CELLS))
      else $error("cell count passed the frame length");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff >= PH_IDLE) && (phase_ff <= PH_DATA))
      else $error("phase left the reachable range");

   a_accept_mul: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MUL))
      else $error("accepted beat did not start the multiply");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_kind_ff == KIND_SHORT) || (rsp_kind_ff == KIND_LONG)))
      else $error("result beat without a frame kind");

endmodule
